@@ rtl/s16_pkg.sv @@
// shared types and constants for the sixteen-bit core
package s16_pkg;
    localparam int MemWordsDefault = 65536;
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_EXEC  = 2'd1;
    localparam logic [1:0] REQ_KEY   = 2'd2;
    localparam logic [15:0] IO_BASE  = 16'hFFF0;
    localparam logic [15:0] KEY_ADDR = 16'hFFFF;
    localparam logic [15:0] RAM_BASE = 16'h0100;

    typedef enum logic [3:0] {
        OP_LOAD, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_SHIFT, OP_MUL,
        OP_STORE, OP_MOVIF, OP_UGT, OP_SGT, OP_ULT, OP_SLT, OP_EQ, OP_JAL
    } opcode_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] load_address;
        logic [15:0] load_data;
        logic [7:0]  key_code;
    } item_t;
endpackage

@@ rtl/s16_queue.sv @@
// two-entry item queue between front and back
module s16_queue
    import s16_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t head
);
    item_t       entry_reg [2];
    logic        wptr_reg, rptr_reg;
    logic [1:0]  count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rptr_reg];

    always_ff @(posedge clk) begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ rtl/s16_exec.sv @@
// execution back end: register file, memory, key latch
module s16_exec
    import s16_pkg::*;
#(
    parameter int MEM_WORDS = MemWordsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        done,
    output logic [15:0] pc_after,
    output logic        reg_written,
    output logic [3:0]  reg_index,
    output logic [15:0] reg_value,
    output logic        mem_written,
    output logic [15:0] mem_address,
    output logic [15:0] mem_value,
    output logic        key_taken
);
    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [16:0] MemLimit = 17'(MEM_WORDS);

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_FETCH, S_DECODE, S_OPER, S_WRITE
    } state_t;

    logic [15:0] mem [MEM_WORDS];
    logic [15:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic        we;
    logic [AW-1:0] wa;
    logic [15:0] wd;

    logic [15:0] rf_reg [16];
    logic [7:0]  key_reg;
    state_t      state_reg;
    logic [AW:0] clr_reg;
    logic [15:0] ir_reg, a_reg, b_reg;
    logic [15:0] pc_reg;
    logic        done_reg;
    logic [15:0] pc_after_reg, reg_value_reg, mem_address_reg, mem_value_reg;
    logic [3:0]  reg_index_reg;
    logic        reg_written_reg, mem_written_reg, key_taken_reg;

    opcode_t     op;
    logic [3:0]  d, s2;
    logic [15:0] val, pc_new, sh;
    logic        wr, st_ok, in_mem_b;
    logic [31:0] prod;
    logic [31:0] sext;
    logic [15:0] fetch_word;

    assign op = opcode_t'(ir_reg[15:12]);
    assign d  = ir_reg[11:8];
    assign s2 = ir_reg[3:0];
    assign in_mem_b = ({1'b0, b_reg} < MemLimit);
    // instruction word, zero when pc is beyond memory
    assign fetch_word = ({1'b0, rf_reg[15]} < MemLimit) ? rd_data_reg : 16'd0;

    always_comb begin
        sext = {{16{a_reg[15]}}, a_reg};
        case (b_reg[5:4])
            2'd0: sh = 16'(sext >> b_reg[3:0]);
            2'd1: sh = a_reg >> b_reg[3:0];
            2'd2: sh = a_reg << b_reg[3:0];
            default: sh = 16'(({a_reg, a_reg} << b_reg[3:0]) >> 16);
        endcase
    end

    assign prod = a_reg * b_reg;
    assign st_ok = (b_reg >= RAM_BASE) && (b_reg < IO_BASE) && in_mem_b;

    always_comb begin
        wr = 1'b1;
        val = 16'd0;
        case (op)
            OP_LOAD:
            begin
                if (b_reg < IO_BASE) val = in_mem_b ? rd_data_reg : 16'd0;
                else if (b_reg == KEY_ADDR) val = {{8{key_reg[7]}}, key_reg};
                else wr = 1'b0;
            end
            OP_ADD:   val = a_reg + b_reg;
            OP_SUB:   val = a_reg - b_reg;
            OP_AND:   val = a_reg & b_reg;
            OP_OR:    val = a_reg | b_reg;
            OP_XOR:   val = a_reg ^ b_reg;
            OP_SHIFT: val = sh;
            OP_MUL:   val = prod[15:0];
            OP_STORE: val = a_reg;
            OP_MOVIF:
            begin
                if (a_reg != 16'd0) val = b_reg;
                else wr = 1'b0;
            end
            OP_UGT: val = {15'd0, a_reg > b_reg};
            OP_SGT: val = {15'd0, $signed(a_reg) > $signed(b_reg)};
            OP_ULT: val = {15'd0, a_reg < b_reg};
            OP_SLT: val = {15'd0, $signed(a_reg) < $signed(b_reg)};
            OP_EQ:  val = {15'd0, a_reg == b_reg};
            default: val = a_reg;
        endcase
        // pc_reg already holds pc+1
        pc_new = (wr && d == 4'd15) ? val : pc_reg;
        if (op == OP_LOAD && s2 == 4'd15 && d != 4'd15) pc_new = pc_reg + 16'd1;
        else if (op == OP_STORE && s2 == 4'd15) pc_new = pc_new + 16'd1;
        else if (op == OP_JAL)
            pc_new = (s2 == 4'd15) ? pc_new : ((wr && d == s2) ? val : rf_reg[s2]);
    end

    // memory port arbitration
    always_comb begin
        we = 1'b0;
        wa = clr_reg[AW-1:0];
        wd = 16'd0;
        rd_addr = rf_reg[15][AW-1:0];
        if (state_reg == S_CLEAR)
        begin
            we = 1'b1;
        end
        else if (state_reg == S_IDLE && q_valid && q_item.req_type == REQ_WRITE)
        begin
            we = ({1'b0, q_item.load_address} < MemLimit);
            wa = q_item.load_address[AW-1:0];
            wd = q_item.load_data;
        end
        else if (state_reg == S_OPER && op == OP_STORE)
        begin
            we = st_ok;
            wa = b_reg[AW-1:0];
            wd = a_reg;
        end
        // data word for a load, ready for write back
        if (state_reg == S_OPER)
        begin
            rd_addr = b_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk) begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            key_reg <= 8'd0;
            done_reg <= 1'b0;
            for (int i = 0; i < 16; i++) rf_reg[i] <= 16'd0;
            pc_reg <= 16'd0;
            ir_reg <= 16'd0;
            a_reg <= 16'd0;
            b_reg <= 16'd0;
            pc_after_reg <= 16'd0;
            reg_written_reg <= 1'b0;
            reg_index_reg <= 4'd0;
            reg_value_reg <= 16'd0;
            mem_written_reg <= 1'b0;
            mem_address_reg <= 16'd0;
            mem_value_reg <= 16'd0;
            key_taken_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_WRITE) ||
                        ((state_reg == S_IDLE) && q_valid && (q_item.req_type != REQ_EXEC));
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(MEM_WORDS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        pc_after_reg <= rf_reg[15];
                        reg_written_reg <= 1'b0;
                        reg_index_reg <= 4'd0;
                        reg_value_reg <= 16'd0;
                        key_taken_reg <= 1'b0;
                        mem_written_reg <= 1'b0;
                        mem_address_reg <= 16'd0;
                        mem_value_reg <= 16'd0;
                        case (q_item.req_type)
                            REQ_WRITE:
                            begin
                                if ({1'b0, q_item.load_address} < MemLimit)
                                begin
                                    mem_written_reg <= 1'b1;
                                    mem_address_reg <= q_item.load_address;
                                    mem_value_reg <= q_item.load_data;
                                end
                            end
                            REQ_KEY:
                            begin
                                key_reg <= q_item.key_code;
                            end
                            REQ_EXEC: state_reg <= S_FETCH;
                            default: ;
                        endcase
                    end
                end
                S_FETCH:
                begin
                    // read of instruction word issued from pc
                    pc_reg <= rf_reg[15] + 16'd1;
                    state_reg <= S_DECODE;
                end
                S_DECODE:
                begin
                    ir_reg <= fetch_word;
                    state_reg <= S_OPER;
                end
                S_OPER:
                begin
                    // data word for load is read now; operands latched last cycle
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_DECODE)
            begin
                a_reg <= (fetch_word[7:4] == 4'd15) ? rf_reg[15] + 16'd1 :
                         rf_reg[fetch_word[7:4]];
                b_reg <= (fetch_word[3:0] == 4'd15) ? rf_reg[15] + 16'd1 :
                         rf_reg[fetch_word[3:0]];
            end
            if (state_reg == S_OPER)
            begin
                if (op == OP_STORE && st_ok)
                begin
                    mem_written_reg <= 1'b1;
                    mem_address_reg <= b_reg;
                    mem_value_reg <= a_reg;
                end
            end
            if (state_reg == S_WRITE)
            begin
                // a write of pc as dest is already folded into pc_new
                if (wr && d != 4'd15) rf_reg[d] <= val;
                rf_reg[15] <= pc_new;
                reg_index_reg <= d;
                reg_written_reg <= wr;
                reg_value_reg <= wr ? val : 16'd0;
                pc_after_reg <= pc_new;
                if (op == OP_LOAD && b_reg == KEY_ADDR)
                begin
                    key_reg <= 8'd0;
                    key_taken_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign pc_after = pc_after_reg;
    assign reg_written = reg_written_reg;
    assign reg_index = reg_index_reg;
    assign reg_value = reg_value_reg;
    assign mem_written = mem_written_reg;
    assign mem_address = mem_address_reg;
    assign mem_value = mem_value_reg;
    assign key_taken = key_taken_reg;
endmodule

@@ rtl/sixteen_bit_cpu_core.sv @@
// top level of the sixteen-bit core
// write and key items pass through the queue and are handled in the idle step;
//   execute items then also pass the fetch, decode, operand and write-back steps
// a new item can wait in the queue while the back end works on the last; the
//   back end takes it once it is back in the idle step
// reset: clears registers, pc and key latch, then a clearing pass over all MEM_WORDS
//   words zeroes memory; an item accepted during that pass waits in the queue
// done pulses one cycle; the receiver cannot stall
module sixteen_bit_cpu_core
    import s16_pkg::*;
#(
    parameter int MEM_WORDS = MemWordsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [15:0] load_address,
    input  logic [15:0] load_data,
    input  logic [7:0]  key_code,
    output logic        done,
    output logic [15:0] pc_after,
    output logic        reg_written,
    output logic [3:0]  reg_index,
    output logic [15:0] reg_value,
    output logic        mem_written,
    output logic [15:0] mem_address,
    output logic [15:0] mem_value,
    output logic        key_taken
);
    // front end: classify and queue the item
    item_t in_item, head;
    logic  full, not_empty, pop;

    assign in_item = '{req_type: req_type, load_address: load_address,
                       load_data: load_data, key_code: key_code};
    // the back end runs one item at a time: results stay in order, no hazards
    assign busy = full | not_empty;

    s16_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(start & ~busy), .push_item(in_item), .full(full),
        .pop(pop), .not_empty(not_empty), .head(head)
    );

    // back end: executes one item
    s16_exec #(.MEM_WORDS(MEM_WORDS)) u_exec (
        .clk(clk), .rst_n(rst_n),
        .q_valid(not_empty), .q_item(head), .q_pop(pop),
        .done(done), .pc_after(pc_after), .reg_written(reg_written),
        .reg_index(reg_index), .reg_value(reg_value),
        .mem_written(mem_written), .mem_address(mem_address),
        .mem_value(mem_value), .key_taken(key_taken)
    );
endmodule
